FILE: hdl/eot_pkg.sv
// ----------------------------------------------------------------------------
// eot_pkg
// Shared types and constants of the ellipsoid occlusion test.
// ----------------------------------------------------------------------------
package eot_pkg;

  localparam int unsigned SlotBits = 20;
  localparam int unsigned RegBits  = 3 * SlotBits;
  localparam int unsigned VecBits  = SlotBits + 1;
  localparam int unsigned IdxBits  = 3;
  localparam int unsigned MidDepth = 4;
  localparam int unsigned OutDepth = 16;

  localparam logic [IdxBits-1:0] REG_AXIS_A    = 3'd0;
  localparam logic [IdxBits-1:0] REG_AXIS_B    = 3'd1;
  localparam logic [IdxBits-1:0] REG_AXIS_C    = 3'd2;
  localparam logic [IdxBits-1:0] REG_CENTRE    = 3'd3;
  localparam logic [IdxBits-1:0] REG_SOURCE    = 3'd4;
  localparam logic [IdxBits-1:0] REG_TARGET    = 3'd5;
  localparam logic [IdxBits-1:0] REG_PROJ_MODE = 3'd6;

  localparam logic PROJ_PARALLEL    = 1'b0;
  localparam logic PROJ_PERSPECTIVE = 1'b1;

  typedef logic signed [VecBits-1:0] vcomp_t;

  // point-minus-centre and view vector, Q.4
  typedef struct packed {
    vcomp_t [2:0] m;
    vcomp_t [2:0] v;
  } mv_t;

endpackage

FILE: hdl/eot_fifo.sv
// ----------------------------------------------------------------------------
// eot_fifo
// Small synchronous queue with first-word-fall-through read.
// ----------------------------------------------------------------------------
module eot_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             rd_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] cnt_q;
  logic               do_wr, do_rd;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntBits'(Depth));
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/eot_front.sv
// ----------------------------------------------------------------------------
// eot_front
// Accepts a point beat and forms the point-minus-centre and view vectors.
// ----------------------------------------------------------------------------
module eot_front
  import eot_pkg::*;
#(
  parameter int unsigned CoordBits = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [SlotBits-1:0] point_x_i,
  input  logic [SlotBits-1:0] point_y_i,
  input  logic [SlotBits-1:0] point_z_i,
  input  logic [RegBits-1:0]  centre_i,
  input  logic [RegBits-1:0]  source_i,
  input  logic [RegBits-1:0]  target_i,
  input  logic                mode_i,
  input  logic                mid_full_i,
  output logic                mid_wr_o,
  output mv_t                 mid_data_o
);

  localparam int unsigned Cw = (CoordBits < SlotBits) ? CoordBits : SlotBits;

  function automatic vcomp_t sx(input logic [SlotBits-1:0] a);
    return vcomp_t'($signed({{(VecBits - Cw){a[Cw-1]}}, a[Cw-1:0]}));
  endfunction

  logic   fr_v_q, fr_v_d;
  mv_t    fr_q, fr_d;
  logic   accept;
  vcomp_t p [3];

  assign p[0] = sx(point_x_i);
  assign p[1] = sx(point_y_i);
  assign p[2] = sx(point_z_i);

  assign mid_wr_o   = fr_v_q && !mid_full_i;
  assign full_o     = fr_v_q && mid_full_i;
  assign accept     = push_i && !full_o;
  assign mid_data_o = fr_q;

  always_comb begin
    fr_d = fr_q;
    for (int k = 0; k < 3; k++) begin
      fr_d.m[k] = p[k] - sx(centre_i[k*SlotBits +: SlotBits]);
      if (mode_i == PROJ_PERSPECTIVE) begin
        fr_d.v[k] = sx(source_i[k*SlotBits +: SlotBits]) - p[k];
      end else begin
        fr_d.v[k] = sx(source_i[k*SlotBits +: SlotBits])
                  - sx(target_i[k*SlotBits +: SlotBits]);
      end
    end
    fr_v_d = accept ? 1'b1 : (mid_wr_o ? 1'b0 : fr_v_q);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fr_q <= fr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_v_q <= 1'b0;
    end else begin
      fr_v_q <= fr_v_d;
    end
  end

endmodule

FILE: hdl/eot_back.sv
// ----------------------------------------------------------------------------
// eot_back
// Nine-stage pipeline: frame mapping, quadratic terms and root-interval test.
// ----------------------------------------------------------------------------
module eot_back
  import eot_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               issue_i,
  input  mv_t                mv_i,
  input  logic [RegBits-1:0] row_a_i,
  input  logic [RegBits-1:0] row_b_i,
  input  logic [RegBits-1:0] row_c_i,
  output logic               res_wr_o,
  output logic               res_o
);

  localparam int unsigned Stages = 9;
  localparam logic signed [17:0]  K5  = 18'sd100000;
  localparam logic signed [34:0]  K10 = 35'sd10000000000;
  localparam logic signed [63:0]  One = 64'sd16777216;

  logic [Stages-1:0] v_q;

  // b1
  mv_t mv_q;
  // b2: row x vector products, rows a,b,c for v then m
  logic signed [40:0] pr_q [6][3];
  // b3
  logic signed [31:0] fr_q [6];
  // b4
  logic signed [63:0] vv_q [3], vm_q [3], mm_q [3];
  // b5
  logic signed [63:0] p5_q, q5_q, r5_q;
  // b6
  logic signed [63:0] qq_hh_q, pr_hh_q;
  logic signed [64:0] qq_hl_q, pr_hl_q, pr_lh_q;
  logic signed [65:0] qq_ll_q, pr_ll_q;
  logic signed [49:0] qk_h_q;
  logic signed [50:0] qk_l_q;
  logic signed [66:0] rk_h_q;
  logic signed [67:0] rk_l_q;
  logic signed [63:0] p6_q, q6_q, r6_q;
  // b7
  logic signed [127:0] qq_q, prr_q, qk_q, rk_q;
  logic signed [63:0]  p7_q, q7_q, r7_q;
  // b8
  logic p_nz_q, disc_neg_q, fe_zero_q, fe_neg_q, f1_neg_q, f1_pos_q, lo_pos_q, hi_pos_q;
  // b9
  logic res_q;

  logic signed [SlotBits-1:0] rc [3][3];
  logic signed [31:0]  qh, ph, rh;
  logic signed [32:0]  ql, pl, rl;
  logic signed [127:0] p128, q128, r128, disc, fe, f1, lo_ok, hi_ok;
  logic signed [42:0]  esum [6];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rc[0][k] = $signed(row_a_i[k*SlotBits +: SlotBits]);
      rc[1][k] = $signed(row_b_i[k*SlotBits +: SlotBits]);
      rc[2][k] = $signed(row_c_i[k*SlotBits +: SlotBits]);
    end
    for (int j = 0; j < 6; j++) begin
      esum[j] = 43'(pr_q[j][0]) + 43'(pr_q[j][1]) + 43'(pr_q[j][2]) + 43'sd512;
    end
    qh = q5_q[63:32];
    ph = p5_q[63:32];
    rh = r5_q[63:32];
    ql = $signed({1'b0, q5_q[31:0]});
    pl = $signed({1'b0, p5_q[31:0]});
    rl = $signed({1'b0, r5_q[31:0]});
    p128  = 128'(p7_q);
    q128  = 128'(q7_q);
    r128  = 128'(r7_q);
    disc  = qq_q - prr_q;
    fe    = p128 + (qk_q <<< 1) + rk_q;
    f1    = p128 + (q128 <<< 1) + r128;
    lo_ok = -qk_q - p128;
    hi_ok = p128 + q128;
  end

  assign res_wr_o = v_q[Stages-1];
  assign res_o    = res_q;

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      mv_q <= mv_i;
    end
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        pr_q[r][k]   <= rc[r][k] * $signed(mv_q.v[k]);
        pr_q[r+3][k] <= rc[r][k] * $signed(mv_q.m[k]);
      end
    end
    for (int j = 0; j < 6; j++) begin
      fr_q[j] <= esum[j][41:10];
    end
    for (int r = 0; r < 3; r++) begin
      vv_q[r] <= fr_q[r] * fr_q[r];
      vm_q[r] <= fr_q[r] * fr_q[r+3];
      mm_q[r] <= fr_q[r+3] * fr_q[r+3];
    end
    p5_q <= vv_q[0] + vv_q[1] + vv_q[2];
    q5_q <= vm_q[0] + vm_q[1] + vm_q[2];
    r5_q <= mm_q[0] + mm_q[1] + mm_q[2] - One;

    qq_hh_q <= qh * qh;
    qq_hl_q <= qh * ql;
    qq_ll_q <= ql * ql;
    pr_hh_q <= ph * rh;
    pr_hl_q <= ph * rl;
    pr_lh_q <= pl * rh;
    pr_ll_q <= pl * rl;
    qk_h_q  <= qh * K5;
    qk_l_q  <= ql * K5;
    rk_h_q  <= rh * K10;
    rk_l_q  <= rl * K10;
    p6_q <= p5_q;
    q6_q <= q5_q;
    r6_q <= r5_q;

    qq_q  <= (128'(qq_hh_q) <<< 64) + (128'(qq_hl_q) <<< 33) + 128'(qq_ll_q);
    prr_q <= (128'(pr_hh_q) <<< 64) + ((128'(pr_hl_q) + 128'(pr_lh_q)) <<< 32)
           + 128'(pr_ll_q);
    qk_q  <= (128'(qk_h_q) <<< 32) + 128'(qk_l_q);
    rk_q  <= (128'(rk_h_q) <<< 32) + 128'(rk_l_q);
    p7_q <= p6_q;
    q7_q <= q6_q;
    r7_q <= r6_q;

    p_nz_q     <= (p7_q != '0);
    disc_neg_q <= disc[127];
    fe_zero_q  <= (fe == '0);
    fe_neg_q   <= fe[127];
    f1_neg_q   <= f1[127];
    f1_pos_q   <= !f1[127] && (f1 != '0);
    lo_pos_q   <= !lo_ok[127] && (lo_ok != '0);
    hi_pos_q   <= !hi_ok[127] && (hi_ok != '0);

    if (!p_nz_q || disc_neg_q) begin
      res_q <= 1'b0;
    end else if (fe_zero_q) begin
      res_q <= 1'b1;
    end else if (fe_neg_q) begin
      res_q <= f1_pos_q;
    end else if (f1_neg_q) begin
      res_q <= 1'b1;
    end else begin
      res_q <= lo_pos_q && hi_pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[Stages-2:0], issue_i};
    end
  end

endmodule

FILE: hdl/ellipsoid_occlusion_test.sv
// ----------------------------------------------------------------------------
// ellipsoid_occlusion_test
// Path: front register, middle queue, fully pipelined back end, result queue.
// Throughput: one point beat per cycle while credits and queue room allow.
// Reset: asynchronous active low; clears queue pointers, credits, valid flags
// and configuration. Front stage and 4-deep middle queue decouple the sides.
// ----------------------------------------------------------------------------
module ellipsoid_occlusion_test
  import eot_pkg::*;
#(
  parameter int unsigned COORD_BITS = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [SlotBits-1:0] point_x_i,
  input  logic [SlotBits-1:0] point_y_i,
  input  logic [SlotBits-1:0] point_z_i,
  output logic                empty,
  input  logic                pop,
  output logic                hidden_o,
  input  logic                cfg_we_i,
  input  logic [IdxBits-1:0]  cfg_index_i,
  input  logic [RegBits-1:0]  cfg_wdata_i
);

  localparam int unsigned CrBits = $clog2(OutDepth + 1);

  logic [RegBits-1:0] row_a_q, row_b_q, row_c_q, centre_q, source_q, target_q;
  logic               mode_q;
  logic [CrBits-1:0]  credit_q;

  logic mid_wr, mid_full, mid_empty, issue, res_wr, res, out_full, out_pop;
  mv_t  mid_wdata, mid_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_a_q  <= '0;
      row_b_q  <= '0;
      row_c_q  <= '0;
      centre_q <= '0;
      source_q <= '0;
      target_q <= '0;
      mode_q   <= PROJ_PARALLEL;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_AXIS_A:    row_a_q  <= cfg_wdata_i;
        REG_AXIS_B:    row_b_q  <= cfg_wdata_i;
        REG_AXIS_C:    row_c_q  <= cfg_wdata_i;
        REG_CENTRE:    centre_q <= cfg_wdata_i;
        REG_SOURCE:    source_q <= cfg_wdata_i;
        REG_TARGET:    target_q <= cfg_wdata_i;
        REG_PROJ_MODE: mode_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  eot_front #(
    .CoordBits(COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .point_z_i  (point_z_i),
    .centre_i   (centre_q),
    .source_i   (source_q),
    .target_i   (target_q),
    .mode_i     (mode_q),
    .mid_full_i (mid_full),
    .mid_wr_o   (mid_wr),
    .mid_data_o (mid_wdata)
  );

  eot_fifo #(
    .Width($bits(mv_t)),
    .Depth(MidDepth)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (mid_wr),
    .wdata_i (mid_wdata),
    .rd_i    (issue),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty),
    .full_o  (mid_full)
  );

  // credits reserve result queue space for every beat in flight
  assign out_pop = pop && !empty;
  assign issue   = !mid_empty && (credit_q < CrBits'(OutDepth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else if (issue && !out_pop) begin
      credit_q <= credit_q + 1'b1;
    end else if (out_pop && !issue) begin
      credit_q <= credit_q - 1'b1;
    end
  end

  eot_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .issue_i  (issue),
    .mv_i     (mid_rdata),
    .row_a_i  (row_a_q),
    .row_b_i  (row_b_q),
    .row_c_i  (row_c_q),
    .res_wr_o (res_wr),
    .res_o    (res)
  );

  eot_fifo #(
    .Width(1),
    .Depth(OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_wr),
    .wdata_i (res),
    .rd_i    (pop),
    .rdata_o (hidden_o),
    .empty_o (empty),
    .full_o  (out_full)
  );

endmodule
